// ----- src/tgc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and constants of the text grid cell updater.
// Used by the sequencer, datapath, top level and checker; depends on nothing.
package tgc_pkg;

  localparam int DEF_MAX_ROWS    = 4;
  localparam int DEF_MAX_COLUMNS = 16;
  localparam int GLYPH_WIDTH     = 8;
  localparam int GLYPH_HEIGHT    = 16;
  localparam int GLYPH_BYTES     = 16;
  localparam int CHAR_W          = 8;

  localparam logic [7:0] CODE_SPACE   = 8'd32;
  localparam logic [7:0] CODE_NEWLINE = 8'd10;

  localparam logic [1:0] OP_SET_CELL   = 2'd0;
  localparam logic [1:0] OP_FILL_ALL   = 2'd1;
  localparam logic [1:0] OP_TEXT_BEGIN = 2'd2;
  localparam logic [1:0] OP_TEXT_CHAR  = 2'd3;

  localparam logic [1:0] CFG_ORIGIN_X     = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y     = 2'd1;
  localparam logic [1:0] CFG_GRID_ROWS    = 2'd2;
  localparam logic [1:0] CFG_GRID_COLUMNS = 2'd3;

  localparam logic [2:0] RST_GRID_ROWS    = 3'd4;
  localparam logic [4:0] RST_GRID_COLUMNS = 5'd16;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] cell_row;
    logic [3:0] cell_column;
    logic [7:0] char_code;
  } in_t;

  typedef struct packed {
    logic [10:0] screen_x;
    logic [10:0] screen_y;
    logic [11:0] glyph_address;
    logic [7:0]  new_char;
    logic        last;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic accept;
    logic write;
    logic load_pend;
    logic push;
    logic push_last;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic has_cell;
    logic changed;
    logic pend_valid;
    logic out_free;
    logic more_cells;
  } status_t;

endpackage

// ----- src/tgc_ram.sv -----
`timescale 1ns / 1ps
// Generic single-port-write, registered-read RAM.
// Self-contained; used for the character cell store.
module tgc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/tgc_ctrl.sv -----
`timescale 1ns / 1ps
// Command sequencer of the text grid cell updater.
// Depends on tgc_pkg; drives the datapath through cmd_t and reads status_t.
module tgc_ctrl
  import tgc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && status.has_cell) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!(status.changed && status.pend_valid && !status.out_free)) begin
          state_nxt = status.more_cells ? ST_READ : ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!status.pend_valid || status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_READ: begin
      end
      ST_CHECK: begin
        if (!(status.changed && status.pend_valid && !status.out_free)) begin
          cmd.write     = status.changed;
          cmd.load_pend = status.changed;
          cmd.push      = status.changed && status.pend_valid;
          cmd.step      = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (status.pend_valid && status.out_free) begin
          cmd.push      = 1'b1;
          cmd.push_last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/tgc_datapath.sv -----
`timescale 1ns / 1ps
// Datapath: configuration registers, cursor, cell walk, cell store and result registers.
// Depends on tgc_pkg and tgc_ram; controlled by tgc_ctrl through cmd_t and status_t.
module tgc_datapath
  import tgc_pkg::*;
#(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  in_t        in_data,
  input  logic       out_stall,
  output logic       out_valid,
  output out_t       out_data,
  input  logic       cfg_wr,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  cmd_t       cmd,
  output status_t    status
);

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [9:0] origin_x_r, origin_y_r;
  logic [2:0] grid_rows_r;
  logic [4:0] grid_columns_r;
  logic [2:0] rows_use;
  logic [4:0] cols_use;

  logic [2:0] cur_row_r, cur_row_nxt;
  logic [4:0] cur_col_r, cur_col_nxt;
  logic [5:0] cur_col_inc;

  logic [2:0]        row_r;
  logic [4:0]        col_r;
  logic [CHAR_W-1:0] code_r;
  logic              single_r;
  logic              has_cell;

  logic [AW-1:0]     addr;
  logic [CHAR_W-1:0] ram_rdata;
  logic [CHAR_W-1:0] cell_now;
  logic [DEPTH-1:0]  written_r;

  out_t pend_r, pend_nxt, out_r, out_nxt;
  logic pend_valid_r, out_valid_r;
  logic out_free, last_col, last_row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r     <= '0;
      origin_y_r     <= '0;
      grid_rows_r    <= RST_GRID_ROWS;
      grid_columns_r <= RST_GRID_COLUMNS;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:     origin_x_r     <= cfg_data;
        CFG_ORIGIN_Y:     origin_y_r     <= cfg_data;
        CFG_GRID_ROWS:    grid_rows_r    <= cfg_data[2:0];
        CFG_GRID_COLUMNS: grid_columns_r <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  assign rows_use = (32'(grid_rows_r) > MAX_ROWS) ? 3'(MAX_ROWS) : grid_rows_r;
  assign cols_use = (32'(grid_columns_r) > MAX_COLUMNS) ? 5'(MAX_COLUMNS) : grid_columns_r;

  always_comb begin
    has_cell = 1'b0;
    case (in_data.opcode) inside
      OP_SET_CELL: has_cell = ({1'b0, in_data.cell_row} < rows_use)
                              && ({1'b0, in_data.cell_column} < cols_use);
      OP_FILL_ALL, OP_TEXT_BEGIN: has_cell = (rows_use != '0) && (cols_use != '0);
      default: has_cell = (cur_row_r < rows_use) && (in_data.char_code != CODE_NEWLINE)
                          && (cur_col_r < cols_use);
    endcase
  end

  assign status.has_cell = has_cell;

  assign cur_col_inc = {1'b0, cur_col_r} + 6'd1;

  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    if (cmd.accept) begin
      if (in_data.opcode == OP_TEXT_BEGIN) begin
        cur_row_nxt = '0;
        cur_col_nxt = '0;
      end else if (in_data.opcode == OP_TEXT_CHAR && cur_row_r < rows_use) begin
        if (in_data.char_code == CODE_NEWLINE || cur_col_inc >= {1'b0, cols_use}) begin
          cur_row_nxt = cur_row_r + 3'd1;
          cur_col_nxt = '0;
        end else begin
          cur_col_nxt = cur_col_inc[4:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
    end else begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
    end
  end

  assign last_col = (col_r == cols_use - 5'd1);
  assign last_row = (row_r == rows_use - 3'd1);
  assign status.more_cells = !single_r && !(last_col && last_row);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      single_r <= (in_data.opcode == OP_SET_CELL) || (in_data.opcode == OP_TEXT_CHAR);
      code_r   <= (in_data.opcode == OP_TEXT_BEGIN) ? CODE_SPACE : in_data.char_code;
      case (in_data.opcode)
        OP_SET_CELL: begin
          row_r <= {1'b0, in_data.cell_row};
          col_r <= {1'b0, in_data.cell_column};
        end
        OP_TEXT_CHAR: begin
          row_r <= cur_row_r;
          col_r <= cur_col_r;
        end
        default: begin
          row_r <= '0;
          col_r <= '0;
        end
      endcase
    end else if (cmd.step) begin
      if (last_col) begin
        row_r <= row_r + 3'd1;
        col_r <= '0;
      end else begin
        col_r <= col_r + 5'd1;
      end
    end
  end

  assign addr = AW'(32'(row_r) * MAX_COLUMNS + 32'(col_r));

  tgc_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.write),
    .waddr(addr),
    .wdata(code_r),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
    end else if (cmd.write) begin
      written_r[addr] <= 1'b1;
    end
  end

  assign cell_now       = written_r[addr] ? ram_rdata : '0;
  assign status.changed = (cell_now != code_r);

  always_comb begin
    pend_nxt.screen_x      = 11'(origin_x_r) + 11'(32'(col_r) * GLYPH_WIDTH);
    pend_nxt.screen_y      = 11'(origin_y_r) + 11'(32'(row_r) * GLYPH_HEIGHT);
    pend_nxt.glyph_address = 12'(32'(code_r) * GLYPH_BYTES);
    pend_nxt.new_char      = code_r;
    pend_nxt.last          = 1'b0;
  end

  always_comb begin
    out_nxt      = pend_r;
    out_nxt.last = cmd.push_last;
  end

  assign out_free          = !out_valid_r || !out_stall;
  assign status.out_free   = out_free;
  assign status.pend_valid = pend_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load_pend) begin
        pend_valid_r <= 1'b1;
      end else if (cmd.push) begin
        pend_valid_r <= 1'b0;
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pend) begin
      pend_r <= pend_nxt;
    end
    if (cmd.push) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- src/text_grid_cell_updater.sv -----
`timescale 1ns / 1ps
// Top level of the text grid cell updater: sequencer plus datapath.
// Depends on tgc_pkg, tgc_ctrl and tgc_datapath.
//
// Each command visits its cells one at a time: for each cell the sequencer reads the
// stored code from the single cell RAM in ST_READ and compares it in ST_CHECK. A
// set-cell or text-character command reaches at most one cell, fill-all and
// text-begin visit every cell of the rows x columns grid, and a command that
// reaches no cell is taken without a walk. A stalled result channel holds the walk
// when a changed cell finds the pending result still waiting. Results are held one
// deep so the final one can carry last; the next command is taken once the last
// result has moved to the output register, while it may still wait there. Per-entry
// valid bits make the store read as zero after reset without a clearing pass.
module text_grid_cell_updater
  import tgc_pkg::*;
#(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  tgc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .status  (status),
    .cmd     (cmd)
  );

  tgc_datapath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLUMNS(MAX_COLUMNS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

// ----- src/tgc_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks of the text grid cell updater, bound to the top level.
// Depends on tgc_pkg and sees only the top-level ports.
module tgc_checker
  import tgc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result changed or dropped.");

  a_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.glyph_address == 12'(32'(out_data.new_char) * GLYPH_BYTES))
    else $error("Glyph address does not match the new character.");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && !in_valid && !(out_valid && out_stall) |=> !out_valid)
    else $error("Result appeared while the block was idle.");

endmodule

bind text_grid_cell_updater tgc_checker u_tgc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);
